/* rtl/single_element_tag_checker_assert.svh */
// Assertion macros used by the checker file of the tag checker.
`ifndef SINGLE_ELEMENT_TAG_CHECKER_ASSERT_SVH
`define SINGLE_ELEMENT_TAG_CHECKER_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define SETC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define SETC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/setc_pkg.sv */
// Package with types, codes and character classes of the tag checker.
package setc_pkg;

    localparam int DEF_MAX_NAME  = 32;
    localparam int DEF_MAX_BYTES = 65536;

    localparam int STATUS_W = 4;
    localparam int NLEN_W   = 6;
    localparam int VOFS_W   = 16;
    localparam int VLEN_W   = 16;
    localparam int RES_W    = STATUS_W + NLEN_W + VOFS_W + VLEN_W;
    localparam int RES_PAD_W = ((RES_W + 7) / 8) * 8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_OPEN   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_UNCLOSED  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_NAME  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NAME_LONG = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TEXT_LONG = 4'd8;

    // Parser phase codes.
    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_LEAD = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_ATTR = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;
    localparam logic [2:0] PH_BAD  = 3'd5;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [VLEN_W-1:0]   value_length;
        logic [VOFS_W-1:0]   value_offset;
        logic [NLEN_W-1:0]   name_length;
        logic [STATUS_W-1:0] status;
    } setc_result_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
    endfunction

    function automatic logic is_start(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == CH_UNDER);
    endfunction

    function automatic logic is_later(input logic [7:0] b);
        return is_start(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_DASH) ||
               (b == CH_DOT) || (b == CH_COLON);
    endfunction

endpackage

/* rtl/setc_core.sv */
// Parser state, tail window and verdict logic of the tag checker.
module setc_core
    import setc_pkg::*;
#(
    parameter int MAX_NAME  = DEF_MAX_NAME,
    parameter int MAX_BYTES = DEF_MAX_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output logic         res_valid,
    output setc_result_t res
);

    localparam int WIN = MAX_NAME + 3;
    localparam int NCW = $clog2(MAX_NAME + 2);
    localparam int JW  = NCW + 2;
    localparam int PW  = $clog2(MAX_BYTES + 2);
    localparam int XW  = $clog2(MAX_BYTES);
    localparam int CW  = (XW > JW) ? XW + 1 : JW + 1;

    logic [2:0]     phase_reg, phase_next;
    logic [NCW-1:0] name_count_reg, name_count_next;
    logic           name_ok_reg, name_ok_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [XW-1:0]  last_pos_reg, last_pos_next;
    logic [XW-1:0]  open_pos_reg, open_pos_next;
    logic           pending_reg, pending_next;
    logic [8:0]     win_reg  [WIN];
    logic [8:0]     win_next [WIN];
    logic [7:0]     name_reg  [MAX_NAME];
    logic [7:0]     name_next [MAX_NAME];
    logic [7:0]     name_ext  [WIN];

    logic           live;
    logic           sp;
    logic           take_name;
    logic           mismatch;
    logic           too_short;
    logic [CW-1:0]  span;
    logic [CW-1:0]  need;
    logic [CW-1:0]  body_len;
    logic [XW:0]    first_value;
    logic [JW-1:0]  n_ext;

    // Next state for one accepted byte.
    always_comb
    begin
        phase_next      = phase_reg;
        name_count_next = name_count_reg;
        name_ok_next    = name_ok_reg;
        pos_next        = pos_reg;
        last_pos_next   = last_pos_reg;
        open_pos_next   = open_pos_reg;
        pending_next    = pending_reg;
        win_next        = win_reg;
        name_next       = name_reg;
        take_name       = 1'b0;
        live            = pos_reg < PW'(MAX_BYTES);
        sp              = is_blank(data_byte);

        if (live)
        begin
            pos_next = pos_reg + PW'(1);
            if (!sp)
            begin
                last_pos_next = pos_reg[XW-1:0];
                for (int i = WIN - 1; i > 0; i--)
                begin
                    win_next[i] = win_reg[i-1];
                end
                win_next[0]  = {pending_reg, data_byte};
                pending_next = 1'b0;
            end
            else
            begin
                pending_next = 1'b1;
            end

            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (!sp)
                    begin
                        phase_next = (data_byte == CH_LT) ? PH_LEAD : PH_BAD;
                    end
                end
                PH_LEAD:
                begin
                    if (data_byte == CH_GT)
                    begin
                        open_pos_next = pos_reg[XW-1:0];
                        phase_next    = PH_BODY;
                    end
                    else if (!sp)
                    begin
                        take_name  = 1'b1;
                        phase_next = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (data_byte == CH_GT)
                    begin
                        open_pos_next = pos_reg[XW-1:0];
                        phase_next    = PH_BODY;
                    end
                    else if (sp)
                    begin
                        phase_next = PH_ATTR;
                    end
                    else
                    begin
                        take_name = 1'b1;
                    end
                end
                PH_ATTR:
                begin
                    if (data_byte == CH_GT)
                    begin
                        open_pos_next = pos_reg[XW-1:0];
                        phase_next    = PH_BODY;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            pos_next = PW'(MAX_BYTES + 1);
        end

        if (take_name)
        begin
            if (name_count_reg == '0)
            begin
                name_ok_next = is_start(data_byte);
            end
            else if (!is_later(data_byte))
            begin
                name_ok_next = 1'b0;
            end
            // The name is kept newest first, so entry 0 holds its last character.
            if (name_count_reg < NCW'(MAX_NAME))
            begin
                for (int i = MAX_NAME - 1; i > 0; i--)
                begin
                    name_next[i] = name_reg[i-1];
                end
                name_next[0] = data_byte;
            end
            if (name_count_reg <= NCW'(MAX_NAME))
            begin
                name_count_next = name_count_reg + NCW'(1);
            end
        end
    end

    // Closing tag check: the newest window entries must read '>', the name
    // backwards, '/' and '<', with no whitespace between them.
    always_comb
    begin
        name_ext[0] = '0;
        for (int i = MAX_NAME + 1; i < WIN; i++)
        begin
            name_ext[i] = '0;
        end
        for (int i = 0; i < MAX_NAME; i++)
        begin
            name_ext[i+1] = name_next[i];
        end

        n_ext    = JW'(name_count_next);
        mismatch = 1'b0;
        for (int j = 0; j < WIN; j++)
        begin
            if (JW'(j) <= n_ext + JW'(2))
            begin
                if (j == 0)
                begin
                    if (win_next[j][7:0] != CH_GT)
                    begin
                        mismatch = 1'b1;
                    end
                end
                else if (JW'(j) <= n_ext)
                begin
                    if (win_next[j][7:0] != name_ext[j])
                    begin
                        mismatch = 1'b1;
                    end
                end
                else if (JW'(j) == n_ext + JW'(1))
                begin
                    if (win_next[j][7:0] != CH_SLASH)
                    begin
                        mismatch = 1'b1;
                    end
                end
                else if (win_next[j][7:0] != CH_LT)
                begin
                    mismatch = 1'b1;
                end
                if (win_next[j][8] && (JW'(j) != n_ext + JW'(2)))
                begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    assign span        = CW'(last_pos_next - open_pos_next);
    assign need        = CW'(name_count_next) + CW'(3);
    assign too_short   = span < need;
    assign body_len    = span - need;
    assign first_value = {1'b0, open_pos_next} + (XW+1)'(1);

    // Verdict in priority order.
    always_comb
    begin
        res = '0;
        if (pos_next > PW'(MAX_BYTES))
        begin
            res.status = ST_TEXT_LONG;
        end
        else if (phase_next == PH_WAIT)
        begin
            res.status = ST_EMPTY;
        end
        else if (phase_next == PH_BAD)
        begin
            res.status = ST_NO_OPEN;
        end
        else if (phase_next != PH_BODY)
        begin
            res.status = ST_UNCLOSED;
        end
        else if (name_count_next == '0 || !name_ok_next)
        begin
            res.status = ST_BAD_NAME;
        end
        else if (name_count_next > NCW'(MAX_NAME))
        begin
            res.status = ST_NAME_LONG;
        end
        else
        begin
            res.name_length = NLEN_W'(name_count_next);
            if (too_short)
            begin
                res.status = ST_SHORT;
            end
            else if (mismatch)
            begin
                res.status = ST_MISMATCH;
            end
            else
            begin
                res.status       = ST_OK;
                res.value_offset = VOFS_W'(first_value);
                res.value_length = VLEN_W'(body_len);
            end
        end
    end

    assign res_valid = take && last_byte;

    // Control state; the last byte of a stream returns it to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            name_count_reg <= '0;
            name_ok_reg    <= 1'b1;
            pos_reg        <= '0;
            last_pos_reg   <= '0;
            open_pos_reg   <= '0;
            pending_reg    <= 1'b0;
            for (int i = 0; i < WIN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            if (last_byte)
            begin
                phase_reg      <= PH_WAIT;
                name_count_reg <= '0;
                name_ok_reg    <= 1'b1;
                pos_reg        <= '0;
                last_pos_reg   <= '0;
                open_pos_reg   <= '0;
                pending_reg    <= 1'b0;
                for (int i = 0; i < WIN; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                phase_reg      <= phase_next;
                name_count_reg <= name_count_next;
                name_ok_reg    <= name_ok_next;
                pos_reg        <= pos_next;
                last_pos_reg   <= last_pos_next;
                open_pos_reg   <= open_pos_next;
                pending_reg    <= pending_next;
                win_reg        <= win_next;
            end
        end
    end

    // Name characters are only read below the current count, so no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            name_reg <= name_next;
        end
    end

endmodule

/* rtl/single_element_tag_checker.sv */
// Top level of the single-element tag checker: stream ports and result buffer.
// The result of a beat marked tlast is registered to m_tdata, via the spare slot if stalled.
// Throughput: one byte beat per cycle unless the spare slot is full; the parser updates its
// state in the accepting cycle. The two-entry buffer lets beats flow while a result waits.
// Reset: rst_n is asynchronous and active low; it empties the buffer and restarts the parser.
// After each beat marked tlast the parser is back in its reset state for the next text.
module single_element_tag_checker
    import setc_pkg::*;
#(
    parameter int MAX_NAME  = DEF_MAX_NAME,
    parameter int MAX_BYTES = DEF_MAX_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte[7:0]
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[3:0], name_length[9:4], value_offset[25:10], value_length[41:26], zeros above
    output logic [RES_PAD_W-1:0] m_tdata
);

    logic         take;
    logic         res_valid;
    setc_result_t res;

    logic         main_valid_reg;
    setc_result_t main_reg;
    logic         skid_valid_reg;
    setc_result_t skid_reg;
    logic         main_free;

    // A byte is taken whenever the spare result slot is empty. That slot only
    // fills when a result arrives while the output register is still stalled.
    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;

    setc_core #(
        .MAX_NAME  (MAX_NAME),
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // The output register can load when it is empty or its beat is taken now.
    assign main_free = !main_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            // The spare slot holds the older result, so it goes out first.
            // While it is full no byte is taken, so no new result competes.
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                main_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = RES_PAD_W'(main_reg);

endmodule

/* rtl/setc_checker.sv */
// Port-level assertions for the tag checker and their bind to the top level.
`include "single_element_tag_checker_assert.svh"

module setc_checker
    import setc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [RES_PAD_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;

    assign st = m_tdata[STATUS_W-1:0];

    // A stalled result beat stays put until it is taken.
    `SETC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // A new result only appears right after an accepted last byte.
    `SETC_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast), "result without a preceding last byte")

    // Only a passing element reports where its value sits.
    `SETC_ASSERT_NOW(a_ofs_only_ok, m_tvalid && st != ST_OK, m_tdata[41:10] == 32'd0, "value fields set on a failing result")

    // A passing element always has a name, and the pad bits above the result are zero.
    `SETC_ASSERT_NOW(a_ok_named, m_tvalid && st == ST_OK, m_tdata[9:4] != 6'd0 && m_tdata[RES_PAD_W-1:RES_W] == '0, "passing result with empty name")

endmodule

bind single_element_tag_checker setc_checker u_setc_checker (.*);
